FILE: hw/rtl/rotated_box_world_bounds_unit_macros.svh
// Assertion macros shared by the RTL of the rotated box bounds unit.
`ifndef ROTATED_BOX_WORLD_BOUNDS_UNIT_MACROS_SVH
`define ROTATED_BOX_WORLD_BOUNDS_UNIT_MACROS_SVH

// Implication checked out of reset.
`define RBWB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbwb: implication check failed");

// Checks what must hold directly after reset is sampled active (low).
`define RBWB_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (rst_n === 1'b0) |=> (cons)) \
    else $error("rbwb: post-reset check failed");

`endif

FILE: hw/rtl/rbwb_pkg.sv
package rbwb_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int TRIG_STAGES   = 16;
  localparam int CORDIC_STAGES = (TRIG_STAGES > 24) ? 24 : TRIG_STAGES;
  localparam int ATAN_IDX_W    = 5;
  localparam int ANGLE_W       = 16;
  localparam int COORD_W       = 32;
  localparam int CXY_W         = 34;  // Q2.30 plus growth headroom
  localparam int Z_W           = 32;
  localparam int TRIG_FRAC     = 15;
  localparam int TRIG_W        = TRIG_FRAC + 2;  // holds -32768..32768
  localparam int PROD_W        = COORD_W + TRIG_W;
  localparam int CORNER_W      = PROD_W + 1;
  localparam int FIN_W         = CORNER_W + 2;

  localparam logic signed [CXY_W-1:0] CORDIC_GAIN = CXY_W'(32'h26DD3B6A);

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [TRIG_W-1:0]   trig_val_t;
  typedef logic signed [CORNER_W-1:0] corner_val_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef enum logic [1:0] {
    REG_LOCAL_LOW_X,
    REG_LOCAL_LOW_Y,
    REG_LOCAL_HIGH_X,
    REG_LOCAL_HIGH_Y
  } cfg_reg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] turn_angle;
    coord_t             pos_x;
    coord_t             pos_y;
  } in_t;

  typedef struct packed {
    coord_t world_low_x;
    coord_t world_low_y;
    coord_t world_high_x;
    coord_t world_high_y;
  } out_t;

  typedef struct packed {
    coord_t local_low_x;
    coord_t local_low_y;
    coord_t local_high_x;
    coord_t local_high_y;
  } box_t;

  typedef struct packed {
    logic signed [CXY_W-1:0] x;
    logic signed [CXY_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    quad_t                   quad;
    coord_t                  pos_x;
    coord_t                  pos_y;
  } cordic_t;

  typedef struct packed {
    corner_val_t [3:0] px;
    corner_val_t [3:0] py;
    coord_t            pos_x;
    coord_t            pos_y;
  } corner_set_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/rotated_box_world_bounds_unit.sv
// Channel  Role      Handshake             Payload
// in_      request   in_valid / in_ready   rbwb_pkg::in_t (turn_angle, pos_x, pos_y)
// out_     result    out_valid / out_ready rbwb_pkg::out_t (world box, Q16.16)
// cfg_     write     cfg_we                cfg_index, cfg_wdata (local box regs)
//
// Throughput: one request per cycle while the output is not stalled, fully pipelined.
// Depth: CORDIC_STAGES + 6 = 22 register stages (16 CORDIC cells, 3 corner
//   stages, 2 min/max stages, output register).
// Reset: synchronous, active low; clears every stage valid and the local box.
// Stalls: a stage holds its data while the stage after it is full and stalled;
//   empty stages keep filling, so requests are taken until all 22 stages are full.
`include "rotated_box_world_bounds_unit_macros.svh"

module rotated_box_world_bounds_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rbwb_pkg::in_t          in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rbwb_pkg::out_t         out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [rbwb_pkg::COORD_W-1:0] cfg_wdata
);
  import rbwb_pkg::*;

  // Local box registers; the user must write them only while the pipeline is drained (not enforced here).
  box_t box_r;
  box_t box_nxt;

  always_comb begin
    box_nxt = box_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOCAL_LOW_X:  box_nxt.local_low_x  = cfg_wdata;
        REG_LOCAL_LOW_Y:  box_nxt.local_low_y  = cfg_wdata;
        REG_LOCAL_HIGH_X: box_nxt.local_high_x = cfg_wdata;
        REG_LOCAL_HIGH_Y: box_nxt.local_high_y = cfg_wdata;
        default:          box_nxt = box_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '0;
    end else begin
      box_r <= box_nxt;
    end
  end

  // Angle split: top two bits pick the quarter turn, the rest is the
  // residual angle in units of 2^-32 turn that drives the CORDIC.
  logic [ANGLE_BITS-1:0] angle;
  cordic_t               head;

  always_comb begin
    angle      = ANGLE_BITS'(in_data.turn_angle);
    head.x     = CORDIC_GAIN;
    head.y     = '0;
    head.z     = Z_W'({angle[ANGLE_BITS-3:0], {(Z_W - ANGLE_BITS){1'b0}}});
    head.quad  = quad_t'(angle[ANGLE_BITS-1 -: 2]);
    head.pos_x = in_data.pos_x;
    head.pos_y = in_data.pos_y;
  end

  // CORDIC chain: cell i does step i and hands its vector to cell i+1.
  cordic_t chain_data  [CORDIC_STAGES + 1];
  logic    chain_valid [CORDIC_STAGES + 1];
  logic    chain_ready [CORDIC_STAGES + 1];

  assign chain_data[0]  = head;
  assign chain_valid[0] = in_valid;
  assign in_ready       = chain_ready[0];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    localparam logic [ATAN_IDX_W-1:0] STEP = ATAN_IDX_W'(g);
    rbwb_cordic_cell u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (STEP),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  // Corner rotation
  logic        corner_valid;
  logic        corner_ready;
  corner_set_t corner_data;

  rbwb_corner_unit u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .box       (box_r),
    .in_valid  (chain_valid[CORDIC_STAGES]),
    .in_ready  (chain_ready[CORDIC_STAGES]),
    .in_data   (chain_data[CORDIC_STAGES]),
    .out_valid (corner_valid),
    .out_ready (corner_ready),
    .out_data  (corner_data)
  );

  // Bounds, position offset, saturation, output register
  rbwb_bound_unit u_bound (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (corner_valid),
    .in_ready  (corner_ready),
    .in_data   (corner_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Low corner never above high corner on either axis.
  logic out_box_ordered;
  assign out_box_ordered = (out_data.world_low_x <= out_data.world_high_x) &&
                           (out_data.world_low_y <= out_data.world_high_y);

  // Input can only back up when every stage is full and the output stalls.
  `RBWB_ASSERT_IMPLY(a_stall_implies_full, clk, rst_n, !in_ready, out_valid && !out_ready)
  // Min and max of one corner set never cross, and rounding is monotonic.
  `RBWB_ASSERT_IMPLY(a_box_ordered, clk, rst_n, out_valid, out_box_ordered)
  // Reset empties the whole pipeline.
  `RBWB_ASSERT_AFTER_RESET(a_reset_empties, clk, rst_n, !out_valid && in_ready)

endmodule

FILE: hw/rtl/rbwb_cordic_cell.sv
// One CORDIC rotation step with its own pipeline register.
module rbwb_cordic_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rbwb_pkg::ATAN_IDX_W-1:0] stage_idx,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rbwb_pkg::cordic_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rbwb_pkg::cordic_t               out_data
);
  import rbwb_pkg::*;

  logic                    v_r;
  cordic_t                 d_r;
  cordic_t                 d_nxt;
  logic signed [CXY_W-1:0] dx;
  logic signed [CXY_W-1:0] dy;
  logic signed [Z_W-1:0]   at;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_comb begin
    dx    = in_data.y >>> stage_idx;
    dy    = in_data.x >>> stage_idx;
    at    = atan_turn(stage_idx);
    d_nxt = in_data;
    if (!in_data.z[Z_W-1]) begin
      d_nxt.x = in_data.x - dx;
      d_nxt.y = in_data.y + dy;
      d_nxt.z = in_data.z - at;
    end else begin
      d_nxt.x = in_data.x + dx;
      d_nxt.y = in_data.y - dy;
      d_nxt.z = in_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: hw/rtl/rbwb_corner_unit.sv
// Rounds sin/cos to Q1.15, unfolds the quadrant, rotates the four corners.
// Three register stages: trig, products, corner sums.
module rbwb_corner_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rbwb_pkg::box_t        box,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rbwb_pkg::cordic_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rbwb_pkg::corner_set_t out_data
);
  import rbwb_pkg::*;

  localparam int RW = CXY_W + 1 - TRIG_FRAC;
  localparam logic signed [RW-1:0]    TRIG_HI = RW'(1 << TRIG_FRAC);
  localparam logic signed [RW-1:0]    TRIG_LO = -TRIG_HI;
  localparam logic signed [CXY_W:0]   RND     = (CXY_W+1)'(1 << (TRIG_FRAC - 1));

  // trig stage
  logic      t_v_r;
  trig_val_t c_r, s_r, c_nxt, s_nxt;
  coord_t    t_px_r, t_py_r;
  // product stage
  logic                     p_v_r;
  logic signed [PROD_W-1:0] lxc_r, lxs_r, hxc_r, hxs_r, lyc_r, lys_r, hyc_r, hys_r;
  coord_t                   p_px_r, p_py_r;
  // sum stage
  logic        s_v_r;
  corner_set_t cs_r, cs_nxt;

  logic t_rdy, p_rdy, s_rdy;

  logic signed [CXY_W:0]  xr, yr;
  logic signed [RW-1:0]   cq, sq;
  trig_val_t              cc, sc;

  assign s_rdy     = !s_v_r || out_ready;
  assign p_rdy     = !p_v_r || s_rdy;
  assign t_rdy     = !t_v_r || p_rdy;
  assign in_ready  = t_rdy;
  assign out_valid = s_v_r;
  assign out_data  = cs_r;

  always_comb begin
    xr = (CXY_W+1)'(in_data.x) + RND;
    yr = (CXY_W+1)'(in_data.y) + RND;
    cq = RW'(xr >>> TRIG_FRAC);
    sq = RW'(yr >>> TRIG_FRAC);
    if (cq > TRIG_HI)      cq = TRIG_HI;
    else if (cq < TRIG_LO) cq = TRIG_LO;
    if (sq > TRIG_HI)      sq = TRIG_HI;
    else if (sq < TRIG_LO) sq = TRIG_LO;
    cc = cq[TRIG_W-1:0];
    sc = sq[TRIG_W-1:0];
    case (in_data.quad)
      QUAD_0:  begin c_nxt = cc;  s_nxt = sc;  end
      QUAD_1:  begin c_nxt = -sc; s_nxt = cc;  end
      QUAD_2:  begin c_nxt = -cc; s_nxt = -sc; end
      QUAD_3:  begin c_nxt = sc;  s_nxt = -cc; end
      default: begin c_nxt = cc;  s_nxt = sc;  end
    endcase
  end

  always_comb begin
    cs_nxt.px[0] = CORNER_W'(lxc_r) - CORNER_W'(lys_r);
    cs_nxt.px[1] = CORNER_W'(lxc_r) - CORNER_W'(hys_r);
    cs_nxt.px[2] = CORNER_W'(hxc_r) - CORNER_W'(hys_r);
    cs_nxt.px[3] = CORNER_W'(hxc_r) - CORNER_W'(lys_r);
    cs_nxt.py[0] = CORNER_W'(lxs_r) + CORNER_W'(lyc_r);
    cs_nxt.py[1] = CORNER_W'(lxs_r) + CORNER_W'(hyc_r);
    cs_nxt.py[2] = CORNER_W'(hxs_r) + CORNER_W'(hyc_r);
    cs_nxt.py[3] = CORNER_W'(hxs_r) + CORNER_W'(lyc_r);
    cs_nxt.pos_x = p_px_r;
    cs_nxt.pos_y = p_py_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      if (t_rdy) t_v_r <= in_valid;
      if (p_rdy) p_v_r <= t_v_r;
      if (s_rdy) s_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && t_rdy) begin
      c_r    <= c_nxt;
      s_r    <= s_nxt;
      t_px_r <= in_data.pos_x;
      t_py_r <= in_data.pos_y;
    end
    if (t_v_r && p_rdy) begin
      lxc_r  <= box.local_low_x  * c_r;
      lxs_r  <= box.local_low_x  * s_r;
      hxc_r  <= box.local_high_x * c_r;
      hxs_r  <= box.local_high_x * s_r;
      lyc_r  <= box.local_low_y  * c_r;
      lys_r  <= box.local_low_y  * s_r;
      hyc_r  <= box.local_high_y * c_r;
      hys_r  <= box.local_high_y * s_r;
      p_px_r <= t_px_r;
      p_py_r <= t_py_r;
    end
    if (p_v_r && s_rdy) begin
      cs_r <= cs_nxt;
    end
  end

endmodule

FILE: hw/rtl/rbwb_bound_unit.sv
// Min/max over the four corners (two compare levels), then position add,
// rounding and saturation into the output register.
module rbwb_bound_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rbwb_pkg::corner_set_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rbwb_pkg::out_t        out_data
);
  import rbwb_pkg::*;

  localparam int SH_W = FIN_W - TRIG_FRAC;
  localparam logic signed [SH_W-1:0] SAT_HI =
    {{(SH_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_LO =
    {{(SH_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};
  localparam logic signed [FIN_W-1:0] RND = FIN_W'(1 << (TRIG_FRAC - 1));

  function automatic corner_val_t min2(input corner_val_t a, input corner_val_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic corner_val_t max2(input corner_val_t a, input corner_val_t b);
    return (b > a) ? b : a;
  endfunction

  function automatic coord_t finish(input corner_val_t c, input coord_t p);
    logic signed [FIN_W-1:0] sum;
    logic signed [SH_W-1:0]  sh;
    sum = FIN_W'(c) + (FIN_W'(p) <<< TRIG_FRAC) + RND;
    sh  = sum[FIN_W-1:TRIG_FRAC];
    if (sh > SAT_HI)      sh = SAT_HI;
    else if (sh < SAT_LO) sh = SAT_LO;
    return sh[COORD_W-1:0];
  endfunction

  // first compare level: pairs {0,1} and {2,3}
  logic        a_v_r;
  corner_val_t a_mnx_r [2];
  corner_val_t a_mxx_r [2];
  corner_val_t a_mny_r [2];
  corner_val_t a_mxy_r [2];
  coord_t      a_px_r, a_py_r;
  // second compare level
  logic        b_v_r;
  corner_val_t b_mnx_r, b_mxx_r, b_mny_r, b_mxy_r;
  coord_t      b_px_r, b_py_r;
  // output register
  logic        o_v_r;
  out_t        o_r, o_nxt;

  logic a_rdy, b_rdy, o_rdy;

  assign o_rdy     = !o_v_r || out_ready;
  assign b_rdy     = !b_v_r || o_rdy;
  assign a_rdy     = !a_v_r || b_rdy;
  assign in_ready  = a_rdy;
  assign out_valid = o_v_r;
  assign out_data  = o_r;

  always_comb begin
    o_nxt.world_low_x  = finish(b_mnx_r, b_px_r);
    o_nxt.world_low_y  = finish(b_mny_r, b_py_r);
    o_nxt.world_high_x = finish(b_mxx_r, b_px_r);
    o_nxt.world_high_y = finish(b_mxy_r, b_py_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (o_rdy) o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_mnx_r[0] <= min2(in_data.px[0], in_data.px[1]);
      a_mnx_r[1] <= min2(in_data.px[2], in_data.px[3]);
      a_mxx_r[0] <= max2(in_data.px[0], in_data.px[1]);
      a_mxx_r[1] <= max2(in_data.px[2], in_data.px[3]);
      a_mny_r[0] <= min2(in_data.py[0], in_data.py[1]);
      a_mny_r[1] <= min2(in_data.py[2], in_data.py[3]);
      a_mxy_r[0] <= max2(in_data.py[0], in_data.py[1]);
      a_mxy_r[1] <= max2(in_data.py[2], in_data.py[3]);
      a_px_r     <= in_data.pos_x;
      a_py_r     <= in_data.pos_y;
    end
    if (a_v_r && b_rdy) begin
      b_mnx_r <= min2(a_mnx_r[0], a_mnx_r[1]);
      b_mxx_r <= max2(a_mxx_r[0], a_mxx_r[1]);
      b_mny_r <= min2(a_mny_r[0], a_mny_r[1]);
      b_mxy_r <= max2(a_mxy_r[0], a_mxy_r[1]);
      b_px_r  <= a_px_r;
      b_py_r  <= a_py_r;
    end
    if (b_v_r && o_rdy) begin
      o_r <= o_nxt;
    end
  end

endmodule

FILE: test/tb_rotated_box_world_bounds_unit.sv
module tb_rotated_box_world_bounds_unit;
  import rbwb_pkg::*;

  // Pipeline depth from the block's header, plus margin for the drain wait.
  localparam int PIPE_LATENCY   = CORDIC_STAGES + 6;
  localparam int SETTLE_CYCLES  = PIPE_LATENCY + 10;
  // Cycles without any request, result or register write before giving up.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CHUNK_REQS     = 50;

  localparam coord_t COORD_MAX = 32'sh7FFFFFFF;
  localparam coord_t COORD_MIN = 32'sh80000000;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  in_t    in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  out_t   out_data;
  logic   cfg_we = 1'b0;
  logic   [1:0] cfg_index = '0;
  coord_t cfg_wdata = '0;

  rotated_box_world_bounds_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // CORDIC step angles, atan(2^-i) in units of 2^-32 turn.
  logic [31:0] atan_step [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Mirror of the local box registers, updated once all four have been written.
  box_t local_box = '0;

  in_t  body_reqs [$];    // requests waiting for the driver
  out_t bounds_due [$];   // world boxes owed by the block, oldest first
  out_t due_box;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cosine and sine of the turn angle in Q1.15, clamped to +/-32768.
  function automatic void turn_cos_sin(input logic [ANGLE_W-1:0] angle,
                                       output longint cs, output longint sn);
    longint x, y, z, dx, dy, c, s;
    quad_t  quad;
    quad = quad_t'(angle[ANGLE_BITS-1 -: 2]);
    // Angle within the quarter turn, scaled to 2^-32 turn.
    z = longint'(angle[ANGLE_BITS-3:0]) <<< (32 - ANGLE_BITS);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_step[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_step[i]);
      end
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (c > 32768) c = 32768;
    if (c < -32768) c = -32768;
    if (s > 32768) s = 32768;
    if (s < -32768) s = -32768;
    case (quad)
      QUAD_0: begin cs = c;  sn = s;  end
      QUAD_1: begin cs = -s; sn = c;  end
      QUAD_2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  // Adds the position to a Q.31 corner extreme, rounds to Q16.16, saturates.
  function automatic coord_t to_world(input longint corner, input coord_t pos);
    longint v;
    v = (corner + longint'(pos) * 32768 + 16384) >>> 15;
    if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return coord_t'(v[31:0]);
  endfunction

  function automatic out_t world_bounds(input in_t req);
    longint cs, sn;
    longint cx [4];
    longint cy [4];
    longint px, py, lo_x, hi_x, lo_y, hi_y;
    out_t   box;
    turn_cos_sin(req.turn_angle, cs, sn);
    // Corners in order: low/low, low/high, high/high, high/low.  No swap
    // when a low register exceeds its high one.
    cx[0] = local_box.local_low_x;  cy[0] = local_box.local_low_y;
    cx[1] = local_box.local_low_x;  cy[1] = local_box.local_high_y;
    cx[2] = local_box.local_high_x; cy[2] = local_box.local_high_y;
    cx[3] = local_box.local_high_x; cy[3] = local_box.local_low_y;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    for (int k = 0; k < 4; k++) begin
      px = cx[k] * cs - cy[k] * sn;
      py = cx[k] * sn + cy[k] * cs;
      if (k == 0 || px < lo_x) lo_x = px;
      if (k == 0 || px > hi_x) hi_x = px;
      if (k == 0 || py < lo_y) lo_y = py;
      if (k == 0 || py > hi_y) hi_y = py;
    end
    box.world_low_x  = to_world(lo_x, req.pos_x);
    box.world_low_y  = to_world(lo_y, req.pos_y);
    box.world_high_x = to_world(hi_x, req.pos_x);
    box.world_high_y = to_world(hi_y, req.pos_y);
    return box;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, with random idle cycles between them.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict at acceptance, against the box in force right now.
      if (in_valid && in_ready) begin
        bounds_due.push_back(world_bounds(in_data));
      end
      // Valid is only touched once the current request has gone.
      if (!in_valid || in_ready) begin
        if (body_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= body_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_coord(input string field, input coord_t want, input coord_t got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (bounds_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: %h", $realtime, out_data);
        end else begin
          due_box = bounds_due.pop_front();
          check_coord("world_low_x",  due_box.world_low_x,  out_data.world_low_x);
          check_coord("world_low_y",  due_box.world_low_y,  out_data.world_low_y);
          check_coord("world_high_x", due_box.world_high_x, out_data.world_high_x);
          check_coord("world_high_y", due_box.world_high_y, out_data.world_high_y);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any request, result or register write counts as progress.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Writes all four local box registers back to back; the block is idle.
  task automatic set_box(input box_t b);
    coord_t vals [4];
    vals[0] = b.local_low_x;
    vals[1] = b.local_low_y;
    vals[2] = b.local_high_x;
    vals[3] = b.local_high_y;
    for (int r = 0; r < 4; r++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(r);
      cfg_wdata <= vals[r];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    local_box = b;
  endtask

  // Sampled on the falling edge so the driver's updates have all landed.
  task automatic drain();
    do @(negedge clk);
    while (body_reqs.size() != 0 || in_valid || bounds_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_t body_req(input logic [15:0] angle, input coord_t x, input coord_t y);
    in_t r;
    r.turn_angle = angle;
    r.pos_x      = x;
    r.pos_y      = y;
    return r;
  endfunction

  // Mix of full-range, near-saturation and everyday positions.
  function automatic coord_t pick_pos();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return COORD_MAX - coord_t'($urandom_range(0, 1 << 20));
      2: return COORD_MIN + coord_t'($urandom_range(0, 1 << 20));
      default: return coord_t'($urandom_range(0, 1 << 25)) - 32'sd16777216;
    endcase
  endfunction

  // Mostly uniform angles, some hugging the quarter-turn boundaries.
  function automatic logic [15:0] pick_angle();
    logic [15:0] a;
    if ($urandom_range(0, 7) == 0) begin
      a = {2'($urandom_range(0, 3)), 14'h0};
      a = a + 16'($urandom_range(0, 4)) - 16'd2;
    end else begin
      a = 16'($urandom_range(0, 65535));
    end
    return a;
  endfunction

  // Box flavors: full random, ordered, saturating extremes, inverted.
  function automatic box_t pick_box(input int kind, input int variant);
    box_t b;
    case (kind)
      0: begin
        b.local_low_x  = coord_t'($urandom);
        b.local_low_y  = coord_t'($urandom);
        b.local_high_x = coord_t'($urandom);
        b.local_high_y = coord_t'($urandom);
      end
      1: begin
        b.local_low_x  = -coord_t'($urandom_range(0, 1 << 22));
        b.local_low_y  = -coord_t'($urandom_range(0, 1 << 22));
        b.local_high_x = coord_t'($urandom_range(0, 1 << 22));
        b.local_high_y = coord_t'($urandom_range(0, 1 << 22));
      end
      2: begin
        // Widest box, or the same extremes swapped.
        b.local_low_x  = variant[0] ? COORD_MAX : COORD_MIN;
        b.local_low_y  = variant[0] ? COORD_MAX : COORD_MIN;
        b.local_high_x = variant[0] ? COORD_MIN : COORD_MAX;
        b.local_high_y = variant[0] ? COORD_MIN : COORD_MAX;
      end
      default: begin
        b.local_low_x  = coord_t'($urandom_range(0, 1 << 22));
        b.local_low_y  = coord_t'($urandom_range(0, 1 << 22));
        b.local_high_x = -coord_t'($urandom_range(0, 1 << 22));
        b.local_high_y = -coord_t'($urandom_range(0, 1 << 22));
      end
    endcase
    return b;
  endfunction

  initial begin
    logic [15:0] dir_angle [8];
    coord_t      dir_pos   [8];
    box_t        dir_box   [3];
    int unsigned phase_send [4];
    int unsigned phase_recv [4];

    // Quarter-turn points, 45 degrees, and both ends of the angle range.
    dir_angle = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                  16'hFFFF, 16'h2000, 16'h0001, 16'h3FFF};
    dir_pos   = '{32'sh0, COORD_MAX, COORD_MIN, 32'sh00010000,
                  -32'sh00010000, 32'sh12345678, 32'sh7FFF8000, 32'sh80008000};
    // Plain box (-3.5,-2.25)..(5.0,1.75), the widest box, an inverted box.
    dir_box[0] = '{-32'sh38000, -32'sh24000, 32'sh50000, 32'sh1C000};
    dir_box[1] = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX};
    dir_box[2] = '{32'sh20000, 32'sh30000, -32'sh10000, -32'sh40000};
    // Idle mixes: none, sender idle, receiver stalling, both.
    phase_send = '{0, 85, 0, 28};
    phase_recv = '{0, 0, 85, 28};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: 24 requests, positions pushed to saturation.
    for (int b = 0; b < 3; b++) begin
      set_box(dir_box[b]);
      for (int i = 0; i < 8; i++)
        body_reqs.push_back(body_req(dir_angle[i], dir_pos[i], dir_pos[(i + 3 + b) % 8]));
      drain();
    end

    // Random part: each idle mix runs three box settings.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      for (int c = 0; c < 3; c++) begin
        set_box(pick_box((p * 3 + c) % 4, p));
        for (int i = 0; i < CHUNK_REQS; i++)
          body_reqs.push_back(body_req(pick_angle(), pick_pos(), pick_pos()));
        drain();
      end
    end

    if (mismatches == 0 && bounds_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
